// ===== hw/rtl/ptc_pkg.sv =====
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared widths, codes and control types of the page translation block.
// ----------------------------------------------------------------------------
package ptc_pkg;

  localparam int unsigned CMD_W      = 3;
  localparam int unsigned ADDR_W     = 48;
  localparam int unsigned ACC_W      = 3;
  localparam int unsigned STAT_W     = 3;
  localparam int unsigned PHYS_W     = 24;
  localparam int unsigned SHIFT_W    = 5;
  localparam int unsigned LIMIT_W    = 9;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned OFF_W      = 16;
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 32;

  localparam logic [SHIFT_W-1:0] SHIFT_MIN     = 5'd12;
  localparam logic [SHIFT_W-1:0] SHIFT_MAX     = 5'd16;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET   = 5'd12;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 9'd256;

  typedef enum logic [CMD_W-1:0] {
    CMD_XLATE  = 3'd0,
    CMD_BYPASS = 3'd1,
    CMD_MAP    = 3'd2,
    CMD_UNMAP  = 3'd3,
    CMD_PROT   = 3'd4
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_PROT    = 3'd2,
    ST_NOFRAME = 3'd3,
    ST_MAPPED  = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAGE_SHIFT  = 2'd0,
    CFG_FRAME_LIMIT = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic fill;
    logic inval;
  } cache_ctl_t;

endpackage

// ===== hw/rtl/page_translation_with_cache_top.sv =====
// ----------------------------------------------------------------------------
// page_translation_with_cache_top
// Page table translation with a translation cache, lazy frame commit and
// map, unmap and set-protection commands.
// ----------------------------------------------------------------------------
// channel  | direction | handshake                | payload
// s_axis   | in        | s_axis_tvalid/tready     | command item
// m_axis   | out       | m_axis_tvalid/tready     | result item
// cfg      | in        | cfg_valid_i/cfg_ready_o  | register index and data
//
// One item per cycle unless a stalled result holds the item behind it or the
// table is clearing. Items pass the stage 1 and then the result register; the
// page table read is registered, the decision and state update follow. After
// reset the table is cleared one entry a cycle, with s_axis_tready low.
// ----------------------------------------------------------------------------
module page_translation_with_cache_top #(
  parameter int unsigned VPN_BITS      = 8,
  parameter int unsigned CACHE_ENTRIES = 4,
  parameter int unsigned FRAMES        = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // cmd[2:0], address[50:3], access[53:51], prot[56:54], commit_now[57]
  input  logic [ptc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // status[2:0], phys_address[26:3], cache_hit[27]
  output logic [ptc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ptc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ptc_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned FW     = $clog2(FRAMES);
  localparam int unsigned NF_W   = FW + 1;
  localparam int unsigned ENT_W  = FW + 5;
  localparam int unsigned CMP_W  = (NF_W > ptc_pkg::LIMIT_W) ? NF_W : ptc_pkg::LIMIT_W;
  localparam int unsigned PW     = FW + ptc_pkg::OFF_W;
  localparam int unsigned WIDE_W = (PW > ptc_pkg::PHYS_W) ? PW : ptc_pkg::PHYS_W;

  // configuration
  logic [ptc_pkg::SHIFT_W-1:0] page_shift_q;
  logic [ptc_pkg::LIMIT_W-1:0] frame_limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_shift_q  <= ptc_pkg::SHIFT_RESET;
      frame_limit_q <= ptc_pkg::LIMIT_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ptc_pkg::CFG_PAGE_SHIFT:  page_shift_q  <= cfg_data_i[ptc_pkg::SHIFT_W-1:0];
        ptc_pkg::CFG_FRAME_LIMIT: frame_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input split
  logic [ptc_pkg::CMD_W-1:0]   in_cmd;
  logic [ptc_pkg::ADDR_W-1:0]  in_addr;
  logic [ptc_pkg::ACC_W-1:0]   in_acc;
  logic [ptc_pkg::ACC_W-1:0]   in_prot;
  logic                        in_commit;
  logic [ptc_pkg::SHIFT_W-1:0] shift_eff;
  logic [ptc_pkg::ADDR_W-1:0]  shifted;
  logic [ptc_pkg::OFF_W-1:0]   in_off;
  logic [VPN_BITS-1:0]         in_vpn;
  logic                        in_bad;

  assign in_cmd    = s_axis_tdata[2:0];
  assign in_addr   = s_axis_tdata[50:3];
  assign in_acc    = s_axis_tdata[53:51];
  assign in_prot   = s_axis_tdata[56:54];
  assign in_commit = s_axis_tdata[57];

  always_comb begin
    if (page_shift_q < ptc_pkg::SHIFT_MIN) begin
      shift_eff = ptc_pkg::SHIFT_MIN;
    end else if (page_shift_q > ptc_pkg::SHIFT_MAX) begin
      shift_eff = ptc_pkg::SHIFT_MAX;
    end else begin
      shift_eff = page_shift_q;
    end
  end

  assign shifted = in_addr >> shift_eff;
  assign in_vpn  = shifted[VPN_BITS-1:0];
  assign in_bad  = |shifted[ptc_pkg::ADDR_W-1:VPN_BITS];
  assign in_off  = in_addr[ptc_pkg::OFF_W-1:0] & ~({ptc_pkg::OFF_W{1'b1}} << shift_eff);

  // stage 1 register
  logic                        s1_valid_q;
  logic [ptc_pkg::CMD_W-1:0]   s1_cmd_q;
  logic [VPN_BITS-1:0]         s1_vpn_q;
  logic [ptc_pkg::OFF_W-1:0]   s1_off_q;
  logic [ptc_pkg::SHIFT_W-1:0] s1_shift_q;
  logic [ptc_pkg::ACC_W-1:0]   s1_acc_q;
  logic [ptc_pkg::ACC_W-1:0]   s1_prot_q;
  logic                        s1_commit_q;
  logic                        s1_bad_q;

  logic out_valid_q;
  logic s1_adv;
  logic in_xfer;
  logic busy;

  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = (!s1_valid_q || s1_adv) && !busy;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_cmd_q    <= in_cmd;
      s1_vpn_q    <= in_vpn;
      s1_off_q    <= in_off;
      s1_shift_q  <= shift_eff;
      s1_acc_q    <= in_acc;
      s1_prot_q   <= in_prot;
      s1_commit_q <= in_commit;
      s1_bad_q    <= in_bad;
    end
  end

  // page table and cache
  logic [ENT_W-1:0] ent;
  logic             wr_en;
  logic [ENT_W-1:0] wr_data;
  logic             hit;
  ptc_pkg::cache_ctl_t cache_ctl;
  ptc_pkg::cache_ctl_t cache_req;

  ptc_table #(
    .VPN_BITS (VPN_BITS),
    .ENT_W    (ENT_W)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_xfer),
    .rd_addr_i (in_vpn),
    .rd_data_o (ent),
    .wr_en_i   (wr_en && s1_adv),
    .wr_addr_i (s1_vpn_q),
    .wr_data_i (wr_data),
    .busy_o    (busy)
  );

  assign cache_ctl.fill  = cache_req.fill && s1_adv;
  assign cache_ctl.inval = cache_req.inval && s1_adv;

  ptc_cache #(
    .VPN_BITS      (VPN_BITS),
    .CACHE_ENTRIES (CACHE_ENTRIES)
  ) u_cache (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vpn_i  (s1_vpn_q),
    .ctl_i  (cache_ctl),
    .hit_o  (hit)
  );

  // decision
  logic                      e_mapped;
  logic                      e_present;
  logic [ptc_pkg::ACC_W-1:0] e_prot;
  logic [FW-1:0]             e_frame;
  logic [NF_W-1:0]           next_frame_q;
  logic                      no_frame;
  logic                      take;
  logic                      phys_en;
  logic                      hit_res;
  ptc_pkg::status_e          status;
  logic [WIDE_W-1:0]         phys_wide;
  logic [FW-1:0]             frame_use;

  assign e_mapped  = ent[FW+4];
  assign e_present = ent[FW+3];
  assign e_prot    = ent[FW+2:FW];
  assign e_frame   = ent[FW-1:0];

  assign no_frame = (CMP_W'(next_frame_q) >= CMP_W'(frame_limit_q)) ||
                    (next_frame_q >= NF_W'(FRAMES));

  always_comb begin
    status          = ptc_pkg::ST_OK;
    take            = 1'b0;
    phys_en         = 1'b0;
    hit_res         = 1'b0;
    wr_en           = 1'b0;
    wr_data         = ent;
    cache_req.fill  = 1'b0;
    cache_req.inval = 1'b0;
    if (s1_bad_q) begin
      status = ptc_pkg::ST_INVALID;
    end else begin
      case (s1_cmd_q) inside
        ptc_pkg::CMD_XLATE, ptc_pkg::CMD_BYPASS: begin
          if (!hit && !e_mapped) begin
            status = ptc_pkg::ST_INVALID;
          end else begin
            hit_res        = hit;
            cache_req.fill = !hit;
            if ((s1_cmd_q == ptc_pkg::CMD_XLATE) && ((e_prot & s1_acc_q) != s1_acc_q)) begin
              status = ptc_pkg::ST_PROT;
            end else if (!e_present && no_frame) begin
              status = ptc_pkg::ST_NOFRAME;
            end else begin
              phys_en = 1'b1;
              if (!e_present) begin
                take    = 1'b1;
                wr_en   = 1'b1;
                wr_data = {1'b1, 1'b1, e_prot, next_frame_q[FW-1:0]};
              end
            end
          end
        end
        ptc_pkg::CMD_MAP: begin
          if (e_mapped) begin
            status = ptc_pkg::ST_MAPPED;
          end else if (s1_commit_q && no_frame) begin
            status = ptc_pkg::ST_NOFRAME;
          end else begin
            take    = s1_commit_q;
            wr_en   = 1'b1;
            wr_data = {1'b1, s1_commit_q, s1_prot_q,
                       s1_commit_q ? next_frame_q[FW-1:0] : {FW{1'b0}}};
          end
        end
        ptc_pkg::CMD_UNMAP: begin
          if (!e_mapped) begin
            status = ptc_pkg::ST_INVALID;
          end else begin
            wr_en           = 1'b1;
            wr_data         = '0;
            cache_req.inval = 1'b1;
          end
        end
        ptc_pkg::CMD_PROT: begin
          if (!e_mapped) begin
            status = ptc_pkg::ST_INVALID;
          end else begin
            wr_en   = 1'b1;
            wr_data = {1'b1, e_present, s1_prot_q, e_frame};
          end
        end
        default: begin
          status = ptc_pkg::ST_INVALID;
        end
      endcase
    end
  end

  assign frame_use = take ? next_frame_q[FW-1:0] : e_frame;
  assign phys_wide = (WIDE_W'(frame_use) << s1_shift_q) | WIDE_W'(s1_off_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_frame_q <= '0;
    end else if (s1_adv && take) begin
      next_frame_q <= next_frame_q + 1'b1;
    end
  end

  // result register
  logic [ptc_pkg::STAT_W-1:0] out_status_q;
  logic [ptc_pkg::PHYS_W-1:0] out_phys_q;
  logic                       out_hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_status_q <= status;
      out_phys_q   <= phys_en ? phys_wide[ptc_pkg::PHYS_W-1:0] : '0;
      out_hit_q    <= hit_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_hit_q, out_phys_q, out_status_q};

endmodule

// ===== hw/rtl/ptc_table.sv =====
// ----------------------------------------------------------------------------
// ptc_table
// Page table memory with registered read, write forwarding and a clearing
// pass after reset.
// ----------------------------------------------------------------------------
module ptc_table #(
  parameter int unsigned VPN_BITS = 8,
  parameter int unsigned ENT_W    = 13
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rd_en_i,
  input  logic [VPN_BITS-1:0] rd_addr_i,
  output logic [ENT_W-1:0]    rd_data_o,
  input  logic                wr_en_i,
  input  logic [VPN_BITS-1:0] wr_addr_i,
  input  logic [ENT_W-1:0]    wr_data_i,
  output logic                busy_o
);

  localparam int unsigned DEPTH = 2 ** VPN_BITS;

  logic [ENT_W-1:0]    mem [DEPTH];
  logic [ENT_W-1:0]    rd_q;
  logic [ENT_W-1:0]    fwd_data_q;
  logic                fwd_q;
  logic                busy_q;
  logic [VPN_BITS-1:0] clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      clr_q  <= '0;
    end else if (busy_q) begin
      clr_q <= clr_q + 1'b1;
      if (clr_q == {VPN_BITS{1'b1}}) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[clr_q] <= '0;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      fwd_data_q <= wr_data_i;
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_q;
  assign busy_o    = busy_q;

endmodule

// ===== hw/rtl/ptc_cache.sv =====
// ----------------------------------------------------------------------------
// ptc_cache
// Fully associative translation cache tags with round-robin refill.
// ----------------------------------------------------------------------------
module ptc_cache #(
  parameter int unsigned VPN_BITS      = 8,
  parameter int unsigned CACHE_ENTRIES = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [VPN_BITS-1:0]   vpn_i,
  input  ptc_pkg::cache_ctl_t   ctl_i,
  output logic                  hit_o
);

  localparam int unsigned IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(CACHE_ENTRIES - 1);

  logic [CACHE_ENTRIES-1:0] valid_q;
  logic [VPN_BITS-1:0]      tag_q [CACHE_ENTRIES];
  logic [IDX_W-1:0]         ptr_q;
  logic [CACHE_ENTRIES-1:0] match;

  always_comb begin
    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      match[i] = valid_q[i] && (tag_q[i] == vpn_i);
    end
  end

  assign hit_o = |match;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ptr_q   <= '0;
    end else if (ctl_i.fill) begin
      valid_q[ptr_q] <= 1'b1;
      ptr_q          <= (ptr_q == LAST) ? '0 : ptr_q + 1'b1;
    end else if (ctl_i.inval) begin
      valid_q <= valid_q & ~match;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.fill) begin
      tag_q[ptr_q] <= vpn_i;
    end
  end

endmodule
